@@ src/csl_pkg.sv @@
package csl_pkg;

   localparam int TableDepthDefault = 256;
   localparam int NumKey = 34;
   localparam logic [5:0] MaxNameDefault = 6'd20;
   localparam logic [5:0] MaxConstDefault = 6'd20;

   localparam logic [5:0] TypeIdent = 6'd34;
   localparam logic [5:0] TypeInteger = 6'd35;
   localparam logic [5:0] TypeDecimal = 6'd36;
   localparam logic [5:0] TypeEnd = 6'd61;

   localparam logic [2:0] ErrNone = 3'd0;
   localparam logic [2:0] ErrNameLong = 3'd1;
   localparam logic [2:0] ErrConstLong = 3'd2;
   localparam logic [2:0] ErrPoint = 3'd3;
   localparam logic [2:0] ErrUnknown = 3'd4;
   localparam logic [2:0] ErrOpenComment = 3'd5;
   localparam logic [2:0] ErrTableFull = 3'd6;

   localparam logic CsrMaxName = 1'b0;
   localparam logic CsrMaxConst = 1'b1;

   typedef enum logic [3:0] {
      SCAN_IDLE = 4'b0001,
      SCAN_NAME = 4'b0010,
      SCAN_NUM  = 4'b0100,
      SCAN_HELD = 4'b1000
   } scan_mode_type;

   typedef enum logic [4:0] {
      PRE_NORMAL = 5'b00001,
      PRE_SLASH  = 5'b00010,
      PRE_LINE   = 5'b00100,
      PRE_BLOCK  = 5'b01000,
      PRE_STAR   = 5'b10000
   } pre_mode_type;

   typedef struct packed {
      logic [5:0] token_type;
      logic [7:0] token_index;
      logic [2:0] error_code;
      logic       last_token;
   } token_type;

   // keyword text, up to 8 characters, zero past the end of the word
   function automatic logic [7:0] kw_char(input int k, input int p);
      string s;
      case (k)
         0: s = "int";      1: s = "void";     2: s = "if";       3: s = "else";
         4: s = "while";    5: s = "return";   6: s = "signed";   7: s = "char";
         8: s = "double";   9: s = "unsigned"; 10: s = "const";   11: s = "goto";
         12: s = "for";     13: s = "float";   14: s = "break";   15: s = "class";
         16: s = "case";    17: s = "do";      18: s = "long";    19: s = "typedef";
         20: s = "static";  21: s = "friend";  22: s = "new";     23: s = "enum";
         24: s = "try";     25: s = "short";   26: s = "continue";
         27: s = "sizeof";  28: s = "switch";  29: s = "private";
         30: s = "catch";   31: s = "delete";  32: s = "public";  33: s = "struct";
         default: s = "";
      endcase
      if (p < s.len()) return s[p];
      return 8'd0;
   endfunction

   function automatic logic [3:0] kw_len(input int k);
      logic [3:0] n;
      n = 4'd9;
      for (int p = 8; p >= 0; p--) begin
         if (kw_char(k, p) == 8'd0) n = 4'(p);
      end
      return n;
   endfunction

endpackage

@@ src/csl_scan.sv @@
// Lexer core: comment stripper and scanner for one byte, all combinational.
module csl_scan
   import csl_pkg::*;
#(
   parameter int TableDepth = TableDepthDefault,
   localparam int CntW = $clog2(TableDepth + 1)
) (
   input  logic [7:0]         c_in,
   input  logic               last_in,
   input  logic [5:0]         max_name,
   input  logic [5:0]         max_const,
   input  pre_mode_type       pre_q,
   input  scan_mode_type      scan_q,
   input  logic [NumKey-1:0]  kw_q,
   input  logic [5:0]         len_q,
   input  logic               over_q,
   input  logic [1:0]         pts_q,
   input  logic [7:0]         held_q,
   input  logic [CntW-1:0]    names_q,
   input  logic [CntW-1:0]    consts_q,
   output pre_mode_type       pre_d,
   output scan_mode_type      scan_d,
   output logic [NumKey-1:0]  kw_d,
   output logic [5:0]         len_d,
   output logic               over_d,
   output logic [1:0]         pts_d,
   output logic [7:0]         held_d,
   output logic [CntW-1:0]    names_d,
   output logic [CntW-1:0]    consts_d,
   output logic [1:0]         n_tok,
   output token_type [2:0]    toks
);

   scan_mode_type      sm;
   logic [NumKey-1:0]  kw;
   logic [5:0]         len;
   logic               over;
   logic [1:0]         pts;
   logic [7:0]         held;
   logic [CntW-1:0]    names, consts;
   pre_mode_type       pm;
   logic [1:0]         n;
   token_type [2:0]    t;

   function automatic token_type mk(logic [5:0] ty, logic [7:0] ix, logic [2:0] e,
                                    logic l);
      token_type r;
      r.token_type = ty; r.token_index = ix; r.error_code = e; r.last_token = l;
      return r;
   endfunction

   function automatic logic is_alpha(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   always_comb begin
      logic [7:0] ch;
      logic       do_scan, do_slash, found, used;
      logic [1:0] pass;
      sm = scan_q; kw = kw_q; len = len_q; over = over_q; pts = pts_q;
      held = held_q; names = names_q; consts = consts_q; pm = pre_q;
      n = 2'd0;
      t = '0;
      do_scan = 1'b0; do_slash = 1'b0; ch = c_in;
      found = 1'b0; used = 1'b0; pass = 2'd0;

      // stripper: decide the scanner calls; up to two (pending '/' then c)
      case (pre_q)
         PRE_LINE: begin
            if (c_in == 8'h0a) pm = PRE_NORMAL;
         end
         PRE_BLOCK, PRE_STAR: begin
            if (c_in == "$") begin
               t[n] = mk(6'd0, 8'd0, ErrOpenComment, 1'b0); n = n + 2'd1;
               pm = PRE_NORMAL;
            end else if (c_in == "*") pm = PRE_STAR;
            else if (c_in == "/" && pre_q == PRE_STAR) pm = PRE_NORMAL;
            else pm = PRE_BLOCK;
         end
         default: begin
            if (pre_q == PRE_SLASH && c_in == "/") pm = PRE_LINE;
            else if (pre_q == PRE_SLASH && c_in == "*") pm = PRE_BLOCK;
            else begin
               // pending slash is scanned as an operator; scanner is idle then
               if (pre_q == PRE_SLASH) begin
                  t[n] = mk(6'd46, 8'd3, ErrNone, 1'b0); n = n + 2'd1;
                  pm = PRE_NORMAL;
               end
               if (c_in == "/") begin
                  do_slash = 1'b1;
                  pm = PRE_SLASH;
               end else if (!(c_in == 8'h0a || c_in == 8'h09 || c_in == 8'h0b ||
                              c_in == 8'h0d)) begin
                  do_scan = 1'b1;
               end
            end
         end
      endcase

      // scanner on ch
      if (do_scan) begin
         if (sm == SCAN_HELD) begin
            found = 1'b1;
            if (held_q == "<" && ch == "=") t[n] = mk(6'd37, 8'd0, ErrNone, 1'b0);
            else if (held_q == ">" && ch == "=") t[n] = mk(6'd38, 8'd1, ErrNone, 1'b0);
            else if (held_q == ":" && ch == "=") t[n] = mk(6'd39, 8'd2, ErrNone, 1'b0);
            else if (held_q == "<" && ch == ">") t[n] = mk(6'd40, 8'd3, ErrNone, 1'b0);
            else if (held_q == "=" && ch == "=") t[n] = mk(6'd41, 8'd4, ErrNone, 1'b0);
            else if (held_q == "!" && ch == "=") t[n] = mk(6'd42, 8'd5, ErrNone, 1'b0);
            else begin
               found = 1'b0; pass = 2'd1;
            end
            // no pair: keep the held character so the flush below emits it alone
            if (found) begin
               n = n + 2'd1; used = 1'b1;
               sm = SCAN_IDLE; held = 8'd0;
            end
         end else if (sm == SCAN_NAME) begin
            if (is_alpha(ch) || is_digit(ch) || ch == "_") begin
               used = 1'b1;
               for (int k = 0; k < NumKey; k++) begin
                  if (len_q >= 6'd8 || kw_char(k, int'(len_q[2:0])) != ch) kw[k] = 1'b0;
               end
               if (len_q == 6'd63 || len_q + 6'd1 > max_name || max_name == 6'd0)
                  over = 1'b1;
               if (len_q != 6'd63) len = len_q + 6'd1;
            end
         end else if (sm == SCAN_NUM) begin
            if (is_digit(ch) || ch == ".") begin
               used = 1'b1;
               if (ch == "." && pts_q != 2'd2) pts = pts_q + 2'd1;
               if (len_q == 6'd63 || len_q + 6'd1 > max_const || max_const == 6'd0)
                  over = 1'b1;
               if (len_q != 6'd63) len = len_q + 6'd1;
            end
         end
      end

      // flush on a slash or on a scan char that ends the token
      for (int f = 0; f < 2; f++) begin
         logic fl;
         fl = (f == 0) ? (do_slash || (do_scan && !used)) : 1'b0;
         if (fl) begin
            if (sm == SCAN_NAME) begin
               logic hit;
               logic [5:0] kk;
               hit = 1'b0; kk = 6'd0;
               for (int k = NumKey - 1; k >= 0; k--) begin
                  if (kw[k] && len == 6'(kw_len(k)) && kw_len(k) < 4'd9) begin
                     hit = 1'b1; kk = 6'(k);
                  end
               end
               if (over) t[n] = mk(6'd0, 8'd0, ErrNameLong, 1'b0);
               else if (hit) t[n] = mk(kk, 8'(kk), ErrNone, 1'b0);
               else if (names >= CntW'(TableDepth))
                  t[n] = mk(6'd0, 8'd0, ErrTableFull, 1'b0);
               else begin
                  t[n] = mk(TypeIdent, 8'(names), ErrNone, 1'b0);
                  names = names + 1'b1;
               end
               n = n + 2'd1;
            end else if (sm == SCAN_NUM) begin
               if (over) t[n] = mk(6'd0, 8'd0, ErrConstLong, 1'b0);
               else if (pts > 2'd1) t[n] = mk(6'd0, 8'd0, ErrPoint, 1'b0);
               else if (consts >= CntW'(TableDepth))
                  t[n] = mk(6'd0, 8'd0, ErrTableFull, 1'b0);
               else begin
                  t[n] = mk((pts == 2'd0) ? TypeInteger : TypeDecimal, 8'(consts),
                            ErrNone, 1'b0);
                  consts = consts + 1'b1;
               end
               n = n + 2'd1;
            end else if (sm == SCAN_HELD) begin
               case (held)
                  "<": t[n] = mk(6'd48, 8'd5, ErrNone, 1'b0);
                  ">": t[n] = mk(6'd49, 8'd6, ErrNone, 1'b0);
                  "=": t[n] = mk(6'd47, 8'd4, ErrNone, 1'b0);
                  ":": t[n] = mk(6'd57, 8'd7, ErrNone, 1'b0);
                  default: t[n] = mk(6'd0, 8'd0, ErrUnknown, 1'b0);
               endcase
               n = n + 2'd1;
            end
            sm = SCAN_IDLE; held = 8'd0;
         end
      end

      // start of a new token or a single-character result
      if (do_scan && !used && ch != " ") begin
         if (is_alpha(ch)) begin
            sm = SCAN_NAME; pts = 2'd0;
            for (int k = 0; k < NumKey; k++) kw[k] = (kw_char(k, 0) == ch);
            over = (max_name == 6'd0);
            len = 6'd1;
         end else if (is_digit(ch)) begin
            sm = SCAN_NUM; kw = '1; pts = 2'd0;
            over = (max_const == 6'd0);
            len = 6'd1;
         end else if (ch == "<" || ch == ">" || ch == ":" || ch == "=" || ch == "!") begin
            sm = SCAN_HELD; held = ch;
         end else begin
            case (ch)
               "+": t[n] = mk(6'd43, 8'd0, ErrNone, 1'b0);
               "-": t[n] = mk(6'd44, 8'd1, ErrNone, 1'b0);
               "*": t[n] = mk(6'd45, 8'd2, ErrNone, 1'b0);
               "(": t[n] = mk(6'd50, 8'd0, ErrNone, 1'b0);
               ")": t[n] = mk(6'd51, 8'd1, ErrNone, 1'b0);
               ",": t[n] = mk(6'd52, 8'd2, ErrNone, 1'b0);
               ";": t[n] = mk(6'd53, 8'd3, ErrNone, 1'b0);
               ".": t[n] = mk(6'd54, 8'd4, ErrNone, 1'b0);
               "[": t[n] = mk(6'd55, 8'd5, ErrNone, 1'b0);
               "]": t[n] = mk(6'd56, 8'd6, ErrNone, 1'b0);
               "{": t[n] = mk(6'd58, 8'd8, ErrNone, 1'b0);
               "}": t[n] = mk(6'd59, 8'd9, ErrNone, 1'b0);
               8'h22: t[n] = mk(6'd60, 8'd10, ErrNone, 1'b0);
               default: t[n] = mk(6'd0, 8'd0, ErrUnknown, 1'b0);
            endcase
            n = n + 2'd1;
         end
      end

      // end of text: a pending slash scans with an idle scanner after a flush
      if (last_in) begin
         if (pm == PRE_SLASH) begin
            t[n] = mk(6'd46, 8'd3, ErrNone, 1'b0); n = n + 2'd1;
         end else if (pm == PRE_BLOCK || pm == PRE_STAR) begin
            t[n] = mk(6'd0, 8'd0, ErrOpenComment, 1'b0); n = n + 2'd1;
         end
         if (sm == SCAN_NAME) begin
            logic hit2;
            logic [5:0] kk2;
            hit2 = 1'b0; kk2 = 6'd0;
            for (int k = NumKey - 1; k >= 0; k--) begin
               if (kw[k] && len == 6'(kw_len(k)) && kw_len(k) < 4'd9) begin
                  hit2 = 1'b1; kk2 = 6'(k);
               end
            end
            if (over) t[n] = mk(6'd0, 8'd0, ErrNameLong, 1'b0);
            else if (hit2) t[n] = mk(kk2, 8'(kk2), ErrNone, 1'b0);
            else if (names >= CntW'(TableDepth))
               t[n] = mk(6'd0, 8'd0, ErrTableFull, 1'b0);
            else t[n] = mk(TypeIdent, 8'(names), ErrNone, 1'b0);
            n = n + 2'd1;
         end else if (sm == SCAN_NUM) begin
            if (over) t[n] = mk(6'd0, 8'd0, ErrConstLong, 1'b0);
            else if (pts > 2'd1) t[n] = mk(6'd0, 8'd0, ErrPoint, 1'b0);
            else if (consts >= CntW'(TableDepth))
               t[n] = mk(6'd0, 8'd0, ErrTableFull, 1'b0);
            else t[n] = mk((pts == 2'd0) ? TypeInteger : TypeDecimal, 8'(consts),
                           ErrNone, 1'b0);
            n = n + 2'd1;
         end else if (sm == SCAN_HELD) begin
            case (held)
               "<": t[n] = mk(6'd48, 8'd5, ErrNone, 1'b0);
               ">": t[n] = mk(6'd49, 8'd6, ErrNone, 1'b0);
               "=": t[n] = mk(6'd47, 8'd4, ErrNone, 1'b0);
               ":": t[n] = mk(6'd57, 8'd7, ErrNone, 1'b0);
               default: t[n] = mk(6'd0, 8'd0, ErrUnknown, 1'b0);
            endcase
            n = n + 2'd1;
         end
         t[n] = mk(TypeEnd, 8'd0, ErrNone, 1'b1); n = n + 2'd1;
         sm = SCAN_IDLE; pm = PRE_NORMAL; kw = '1; len = 6'd0; over = 1'b0;
         pts = 2'd0; held = 8'd0; names = '0; consts = '0;
      end
      if (pass == 2'd3) n = 2'd0;
   end

   assign pre_d = pm;
   assign scan_d = sm;
   assign kw_d = kw;
   assign len_d = len;
   assign over_d = over;
   assign pts_d = pts;
   assign held_d = held;
   assign names_d = names;
   assign consts_d = consts;
   assign n_tok = n;
   assign toks = t;

endmodule

@@ src/c_subset_lexer.sv @@
// A request is registered, and its first token shows on rsp_ in the cycle after it is taken.
// Throughput: one byte per cycle while each byte yields at most one token and
// rsp_tready is high; a byte that yields two or three tokens holds req_tready low
// until its last token is taken. Lexing itself is one registered pass per byte.
// Reset (synchronous, active high) clears scan state, counters and limits (both 20).
module c_subset_lexer
   import csl_pkg::*;
#(
   parameter int TableDepth = TableDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_in
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [5:0] token_type, [13:6] token_index,
                                    // [16:14] error_code, [23:17] zero
   output logic        rsp_tlast,   // last_token
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [5:0]  csr_data
);

   localparam int CntW = $clog2(TableDepth + 1);

   // configuration limits
   logic [5:0] max_name_ff, max_const_ff;

   // lexer state
   pre_mode_type      pre_ff, pre_in;
   scan_mode_type     scan_ff, scan_in;
   logic [NumKey-1:0] kw_ff, kw_in;
   logic [5:0]        len_ff, len_in;
   logic              over_ff, over_in;
   logic [1:0]        pts_ff, pts_in;
   logic [7:0]        held_ff, held_in;
   logic [CntW-1:0]   names_ff, names_in, consts_ff, consts_in;

   // token buffer: up to three tokens from one byte, drained one per handshake
   token_type [2:0] buf_ff, buf_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic [1:0]      rd_ff, rd_in;

   logic [1:0]      n_tok;
   token_type [2:0] toks;
   logic            take, pop;

   csl_scan #(.TableDepth(TableDepth)) u_scan (
      .c_in(req_tdata), .last_in(req_tlast),
      .max_name(max_name_ff), .max_const(max_const_ff),
      .pre_q(pre_ff), .scan_q(scan_ff), .kw_q(kw_ff), .len_q(len_ff),
      .over_q(over_ff), .pts_q(pts_ff), .held_q(held_ff),
      .names_q(names_ff), .consts_q(consts_ff),
      .pre_d(pre_in), .scan_d(scan_in), .kw_d(kw_in), .len_d(len_in),
      .over_d(over_in), .pts_d(pts_in), .held_d(held_in),
      .names_d(names_in), .consts_d(consts_in),
      .n_tok(n_tok), .toks(toks)
   );

   // output token is the one at the read pointer
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata = {7'd0, buf_ff[rd_ff].error_code, buf_ff[rd_ff].token_index,
                       buf_ff[rd_ff].token_type};
   assign rsp_tlast = buf_ff[rd_ff].last_token;
   assign pop = rsp_tvalid && rsp_tready;
   // accept when the buffer empties this cycle (last one leaving) or is empty
   assign req_tready = (cnt_ff == 2'd0) || (cnt_ff == 2'd1 && rsp_tready);
   assign take = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      rd_in = rd_ff;
      if (pop) begin
         cnt_in = cnt_ff - 2'd1;
         rd_in = rd_ff + 2'd1;
      end
      if (take) begin
         buf_in = toks;
         cnt_in = n_tok;
         rd_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_name_ff <= MaxNameDefault;
         max_const_ff <= MaxConstDefault;
         pre_ff <= PRE_NORMAL;
         scan_ff <= SCAN_IDLE;
         kw_ff <= '1;
         len_ff <= '0;
         over_ff <= 1'b0;
         pts_ff <= '0;
         held_ff <= '0;
         names_ff <= '0;
         consts_ff <= '0;
         cnt_ff <= '0;
         rd_ff <= '0;
      end else begin
         if (csr_valid && csr_index == CsrMaxName) max_name_ff <= csr_data;
         if (csr_valid && csr_index == CsrMaxConst) max_const_ff <= csr_data;
         // advance lexer state on every accepted request
         if (take) begin
            pre_ff <= pre_in;
            scan_ff <= scan_in;
            kw_ff <= kw_in;
            len_ff <= len_in;
            over_ff <= over_in;
            pts_ff <= pts_in;
            held_ff <= held_in;
            names_ff <= names_in;
            consts_ff <= consts_in;
         end
         cnt_ff <= cnt_in;
         rd_ff <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

endmodule

@@ src/csl_checker.sv @@
module csl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp dropped while stalled");

   a_end_type: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[5:0] == 6'd61)
      else $error("end token has wrong type");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:17] == 7'd0 && rsp_tdata[16:14] <= 3'd6)
      else $error("bad rsp padding or error code");

   a_stall_in: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while tokens still pending");

endmodule

bind c_subset_lexer csl_checker u_csl_checker (
   .clock(clock), .reset(reset),
   .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
);
